[rtl/elg_pkg.sv]
// Shared types and constants of the elliptical Gaussian patch block.
`default_nettype none
package elg_pkg;

    localparam int CENTER_W  = 20;
    localparam int COORD_BITS = 12;
    localparam int DX_W      = 22;
    localparam int CLIP_W    = 28;
    localparam int SUM_W     = 24;
    localparam int RCP_W     = 33;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [15:0] HALF_LOG2E_Q16 = 16'd47274;
    localparam logic [63:0] LN2_Q32        = 64'd2977044472;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd2;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic signed [15:0]  cos_angle;
        logic signed [15:0]  sin_angle;
        logic [15:0]         inv_major;
        logic [15:0]         inv_minor;
    } elg_req_t;

    typedef struct packed {
        logic [15:0]           pixel_value;
        logic [2:0]            tile_col;
        logic [2:0]            tile_row;
        logic [COORD_BITS-1:0] offset_x;
        logic [COORD_BITS-1:0] offset_y;
        logic                  empty_patch;
        logic                  last;
    } elg_res_t;

    typedef struct packed {
        logic load;
        logic clip;
        logic fill_vld;
        logic div_go;
        logic rd_vld;
        logic rd_last;
        logic emit_empty;
    } elg_cmd_t;

    typedef struct packed {
        logic empty;
        logic fill_busy;
        logic div_done;
        logic out_busy;
    } elg_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_BOX,
        ST_FILL,
        ST_DRAIN,
        ST_DIV,
        ST_DIVW,
        ST_EMIT,
        ST_FLUSH
    } elg_state_t;

endpackage
`default_nettype wire

[rtl/elg_div.sv]
// Restoring divider: floor(2^32 / den), one quotient bit per cycle.
`default_nettype none
module elg_div
    import elg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [SUM_W-1:0] den,
    output logic      [RCP_W-1:0] quo,
    output logic                  done
);

    logic [5:0]       cnt_reg;
    logic [SUM_W:0]   rem_reg;
    logic [RCP_W-1:0] q_reg;
    logic             done_reg;
    logic [SUM_W:0]   rem_sh;
    logic             fits;

    // the dividend has its only set bit at the top
    assign rem_sh = {rem_reg[SUM_W-1:0], (cnt_reg == 6'(RCP_W))};
    assign fits   = (rem_sh >= (SUM_W+1)'(den));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 6'd1);
            if (go)
                cnt_reg <= 6'(RCP_W);
            else if (cnt_reg != 6'd0)
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (cnt_reg != 6'd0)
        begin
            rem_reg <= fits ? rem_sh - (SUM_W+1)'(den) : rem_sh;
            q_reg   <= {q_reg[RCP_W-2:0], fits};
        end
    end

    assign quo  = (den == '0) ? '0 : q_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[rtl/elg_datapath.sv]
// Datapath: config registers, box clipping, pixel pipeline, buffer and output stage.
`default_nettype none
module elg_datapath
    import elg_pkg::*;
#(
    parameter int MAX_RADIUS      = 4,
    parameter int FRAC_BITS       = 8,
    parameter int EXP_TABLE_DEPTH = 64,
    localparam int SIDE = 2 * MAX_RADIUS,
    localparam int PW   = (SIDE > 2) ? $clog2(SIDE) : 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire elg_req_t             request,
    input  wire elg_cmd_t             cmd,
    input  wire logic [PW-1:0]        col,
    input  wire logic [PW-1:0]        row,
    output elg_sts_t                  sts,
    output logic      [PW-1:0]        wm1,
    output logic      [PW-1:0]        hm1,
    output elg_res_t                  result,
    output logic                      result_valid
);

    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int KIW   = $clog2(EXP_TABLE_DEPTH);
    localparam int UMW   = FRAC_BITS + 3;
    localparam int Q2W   = 2 * UMW + 1;
    localparam int WPW   = Q2W + 16;
    localparam int XW    = CENTER_W + FRAC_BITS + 2;

    function automatic logic [15:0] exp2_entry(input int unsigned k);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        a    = (64'(k) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        for (int n = 1; n <= 16; n++)
        begin
            term = ((term * a) >> 32) / 64'(n);
            if ((n & 1) != 0)
                neg = neg + term;
            else
                pos = pos + term;
        end
        return 16'(((pos - neg) + 64'd65536) >> 17);
    endfunction

    function automatic logic [CENTER_W+CLIP_W-1:0] clip_axis(
        input logic [CENTER_W-1:0] c,
        input logic [12:0]         dim,
        input logic [3:0]          r
    );
        logic signed [CLIP_W-1:0] lo;
        logic signed [CLIP_W-1:0] hi;
        logic signed [CLIP_W-1:0] lim;
        logic signed [CLIP_W-1:0] org;
        logic signed [CLIP_W-1:0] sz;
        lo  = signed'(CLIP_W'(c)) - signed'(CLIP_W'({r, {FRAC_BITS{1'b0}}}));
        hi  = signed'(CLIP_W'(c)) + signed'(CLIP_W'({r, {FRAC_BITS{1'b0}}}));
        lim = signed'(CLIP_W'(dim)) - CLIP_W'(1);
        org = (lo < 0) ? '0 : (lo >>> FRAC_BITS);
        if (hi > (lim <<< FRAC_BITS))
            sz = lim - org;
        else
            sz = (hi >>> FRAC_BITS) - org;
        return {org[CENTER_W-1:0], sz};
    endfunction

    function automatic logic signed [24:0] rnd14(input logic signed [38:0] v);
        logic [38:0]        mag;
        logic signed [24:0] t;
        mag = v[38] ? 39'(-v) : 39'(v);
        mag = (mag + (39'd1 << 13)) >> 14;
        t   = signed'(mag[24:0]);
        return v[38] ? -t : t;
    endfunction

    function automatic logic signed [29:0] rnd12(input logic signed [41:0] v);
        logic [41:0]        mag;
        logic signed [29:0] t;
        mag = v[41] ? 42'(-v) : 42'(v);
        mag = (mag + (42'd1 << 11)) >> 12;
        t   = signed'(mag[29:0]);
        return v[41] ? -t : t;
    endfunction

    function automatic logic [CLIP_W-1:0] clamp_m1(input logic signed [CLIP_W-1:0] s);
        return (s > CLIP_W'(SIDE)) ? CLIP_W'(SIDE - 1) : CLIP_W'(s - CLIP_W'(1));
    endfunction

    // constant 2^-x table
    logic [15:0] exp_tab [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_exp
        localparam logic [15:0] ENTRY = exp2_entry(g);
        assign exp_tab[g] = ENTRY;
    end

    // configuration
    logic [2:0]  radius_reg;
    logic [12:0] cols_reg;
    logic [12:0] rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 3'd3;
            cols_reg   <= 13'd4096;
            rows_reg   <= 13'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data[2:0];
                CFG_COLS:   cols_reg   <= cfg_data;
                CFG_ROWS:   rows_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // request and box
    elg_req_t              req_reg;
    logic [CENTER_W-1:0]   ox_reg;
    logic [CENTER_W-1:0]   oy_reg;
    logic                  empty_reg;
    logic [PW-1:0]         wm1_reg;
    logic [PW-1:0]         hm1_reg;
    logic [3:0]            r_eff;
    logic [CENTER_W+CLIP_W-1:0] cx_box;
    logic [CENTER_W+CLIP_W-1:0] cy_box;
    logic signed [CLIP_W-1:0]   sw;
    logic signed [CLIP_W-1:0]   shh;
    logic [CLIP_W-1:0]          wc;
    logic [CLIP_W-1:0]          hc;

    assign r_eff  = (4'(radius_reg) > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : 4'(radius_reg);
    assign cx_box = clip_axis(req_reg.center_x, cols_reg, r_eff);
    assign cy_box = clip_axis(req_reg.center_y, rows_reg, r_eff);
    assign sw     = signed'(cx_box[CLIP_W-1:0]);
    assign shh    = signed'(cy_box[CLIP_W-1:0]);
    assign wc     = clamp_m1(sw);
    assign hc     = clamp_m1(shh);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= request;
        if (cmd.clip)
        begin
            ox_reg    <= cx_box[CENTER_W+CLIP_W-1:CLIP_W];
            oy_reg    <= cy_box[CENTER_W+CLIP_W-1:CLIP_W];
            empty_reg <= (sw <= 0) || (shh <= 0);
            wm1_reg   <= wc[PW-1:0];
            hm1_reg   <= hc[PW-1:0];
        end
    end

    // pixel pipeline, stages 1 to 8
    logic [8:1]   v_reg;
    logic [AW-1:0] a_reg [8:1];

    logic [CENTER_W-1:0]   px;
    logic [CENTER_W-1:0]   py;
    logic signed [XW-1:0]  dxf;
    logic signed [XW-1:0]  dyf;
    assign px  = ox_reg + CENTER_W'(col);
    assign py  = oy_reg + CENTER_W'(row);
    assign dxf = signed'(XW'({px, {FRAC_BITS{1'b0}}})) - signed'(XW'(req_reg.center_x));
    assign dyf = signed'(XW'({py, {FRAC_BITS{1'b0}}})) - signed'(XW'(req_reg.center_y));

    logic signed [DX_W-1:0] dx_reg, dy_reg;
    logic signed [37:0]     m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [24:0]     xt_reg, yt_reg;
    logic signed [41:0]     pu_reg, pv_reg;
    logic [UMW-1:0]         um_reg, vm_reg;
    logic                   big4_reg;
    logic [2*UMW-1:0]       uu_reg, vv_reg;
    logic                   big5_reg;
    logic [WPW-1:0]         wp_reg;
    logic                   big6_reg;
    logic [KIW-1:0]         k_reg;
    logic [3:0]             sh_reg;
    logic                   zero_reg;

    logic signed [29:0]     u_c, v_c;
    logic [29:0]            um_c, vm_c;
    logic [Q2W-1:0]         q2_c;
    logic [WPW:0]           wr_c;
    logic [23:0]            w_c;
    logic [27:0]            kp_c;
    logic                   wrap_c;
    logic [8:0]             ipx_c;
    logic [15:0]            val_c;

    assign u_c    = rnd12(pu_reg);
    assign v_c    = rnd12(pv_reg);
    assign um_c   = u_c[29] ? 30'(-u_c) : 30'(u_c);
    assign vm_c   = v_c[29] ? 30'(-v_c) : 30'(v_c);
    assign q2_c   = Q2W'(uu_reg) + Q2W'(vv_reg);
    assign wr_c   = (WPW+1)'(wp_reg) + ((WPW+1)'(1) << (2 * FRAC_BITS - 1));
    assign w_c    = wr_c[2*FRAC_BITS+23:2*FRAC_BITS];
    assign kp_c   = (28'(w_c[15:0]) * 28'(EXP_TABLE_DEPTH) + 28'd32768) >> 16;
    assign wrap_c = (kp_c >= 28'(EXP_TABLE_DEPTH));
    assign ipx_c  = 9'(w_c[23:16]) + 9'(wrap_c);
    assign val_c  = zero_reg ? 16'd0 : (exp_tab[k_reg] >> sh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[7:1], cmd.fill_vld};
    end

    always_ff @(posedge clk)
    begin
        a_reg[1] <= AW'(int'(col) * SIDE + int'(row));
        for (int i = 2; i <= 8; i++)
            a_reg[i] <= a_reg[i-1];
        // stage 1: offsets from the center
        dx_reg   <= dxf[DX_W-1:0];
        dy_reg   <= dyf[DX_W-1:0];
        // stage 2: rotation products
        m1_reg   <= dx_reg * req_reg.cos_angle;
        m2_reg   <= dy_reg * req_reg.sin_angle;
        m3_reg   <= dy_reg * req_reg.cos_angle;
        m4_reg   <= dx_reg * req_reg.sin_angle;
        // stage 3: rotated offsets
        xt_reg   <= rnd14(39'(m1_reg) + 39'(m2_reg));
        yt_reg   <= rnd14(39'(m3_reg) - 39'(m4_reg));
        // stage 4: axis scaling
        pu_reg   <= 42'(xt_reg) * signed'({26'd0, req_reg.inv_major});
        pv_reg   <= 42'(yt_reg) * signed'({26'd0, req_reg.inv_minor});
        // stage 5: round; a huge magnitude underflows the exponent anyway
        um_reg   <= um_c[UMW-1:0];
        vm_reg   <= vm_c[UMW-1:0];
        big4_reg <= (um_c >= (30'd1 << UMW)) || (vm_c >= (30'd1 << UMW));
        // stage 6: squares
        uu_reg   <= um_reg * um_reg;
        vv_reg   <= vm_reg * vm_reg;
        big5_reg <= big4_reg;
        // stage 7: exponent in base 2
        wp_reg   <= WPW'(q2_c) * WPW'(HALF_LOG2E_Q16);
        big6_reg <= big5_reg;
        // stage 8: table index and shift
        k_reg    <= wrap_c ? '0 : kp_c[KIW-1:0];
        sh_reg   <= ipx_c[3:0];
        zero_reg <= big6_reg || (ipx_c >= 9'd16);
    end

    // patch buffer and running sum
    logic [15:0]      pbuf_mem [DEPTH];
    logic [SUM_W-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (v_reg[8])
            pbuf_mem[a_reg[8]] <= val_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (cmd.clip)
            sum_reg <= '0;
        else if (v_reg[8])
            sum_reg <= sum_reg + SUM_W'(val_c);
    end

    // reciprocal of the sum
    logic [RCP_W-1:0] rcp;
    logic             div_done;

    elg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .den   (sum_reg),
        .quo   (rcp),
        .done  (div_done)
    );

    // emit pipeline: read, multiply, round
    logic          e1_reg, e2_reg;
    logic [2:0]    c1_reg, r1_reg, c2_reg, r2_reg;
    logic          l1_reg, l2_reg;
    logic [15:0]   rd_reg;
    logic [48:0]   prod_reg;
    logic [33:0]   p_c;
    elg_res_t      res_reg;
    logic          strobe_reg;

    assign p_c = 34'((50'(prod_reg) + 50'd32768) >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg     <= 1'b0;
            e2_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            e1_reg     <= cmd.rd_vld;
            e2_reg     <= e1_reg;
            strobe_reg <= e2_reg || cmd.emit_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_vld)
            rd_reg <= pbuf_mem[AW'(int'(col) * SIDE + int'(row))];
        c1_reg   <= 3'(col);
        r1_reg   <= 3'(row);
        l1_reg   <= cmd.rd_last;
        c2_reg   <= c1_reg;
        r2_reg   <= r1_reg;
        l2_reg   <= l1_reg;
        prod_reg <= 49'(rd_reg) * 49'(rcp);
        if (cmd.emit_empty)
        begin
            res_reg.pixel_value <= '0;
            res_reg.tile_col    <= '0;
            res_reg.tile_row    <= '0;
            res_reg.empty_patch <= 1'b1;
            res_reg.last        <= 1'b1;
        end
        else
        begin
            res_reg.pixel_value <= (p_c > 34'd65535) ? 16'hFFFF : p_c[15:0];
            res_reg.tile_col    <= c2_reg;
            res_reg.tile_row    <= r2_reg;
            res_reg.empty_patch <= 1'b0;
            res_reg.last        <= l2_reg;
        end
        res_reg.offset_x <= ox_reg[COORD_BITS-1:0];
        res_reg.offset_y <= oy_reg[COORD_BITS-1:0];
    end

    assign sts.empty     = empty_reg;
    assign sts.fill_busy = |v_reg;
    assign sts.div_done  = div_done;
    assign sts.out_busy  = e1_reg || e2_reg;
    assign wm1           = wm1_reg;
    assign hm1           = hm1_reg;
    assign result        = res_reg;
    assign result_valid  = strobe_reg;

endmodule
`default_nettype wire

[rtl/elg_ctrl.sv]
// Controller: sequences clipping, fill, reciprocal and emit phases.
`default_nettype none
module elg_ctrl
    import elg_pkg::*;
#(
    parameter int PW = 3
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire elg_sts_t      sts,
    input  wire logic [PW-1:0] wm1,
    input  wire logic [PW-1:0] hm1,
    output elg_cmd_t           cmd,
    output logic      [PW-1:0] col,
    output logic      [PW-1:0] row,
    output logic               busy
);

    elg_state_t    state_reg, state_next;
    logic [PW-1:0] col_reg, col_next;
    logic [PW-1:0] row_reg, row_next;
    logic          at_end;

    assign at_end = (col_reg == wm1) && (row_reg == hm1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = ST_BOX;
            end
            ST_BOX:
            begin
                col_next = '0;
                row_next = '0;
                if (sts.empty)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_FLUSH;
                end
                else
                    state_next = ST_FILL;
            end
            ST_FILL, ST_EMIT:
            begin
                if (state_reg == ST_FILL)
                    cmd.fill_vld = 1'b1;
                else
                begin
                    cmd.rd_vld  = 1'b1;
                    cmd.rd_last = at_end;
                end
                // column outer, row inner
                if (row_reg == hm1)
                begin
                    row_next = '0;
                    col_next = col_reg + PW'(1);
                end
                else
                    row_next = row_reg + PW'(1);
                if (at_end)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = (state_reg == ST_FILL) ? ST_DRAIN : ST_FLUSH;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.fill_busy)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_go = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (sts.div_done)
                    state_next = ST_EMIT;
            end
            ST_FLUSH:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign col  = col_reg;
    assign row  = row_reg;
    assign busy = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

[rtl/elliptical_gaussian_patch.sv]
// Top level of the normalized elliptical Gaussian patch generator.
//
//  channel   signals                            transfer when
//  ------    ---------------------------------  ---------------------------
//  request   start, busy, request               start && !busy
//  result    result_valid, result               result_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index,   cfg_valid && cfg_ready
//            cfg_data
//
// A request holds busy after its transfer through the clip, fill, drain,
// divide, emit and flush states; an empty box goes from clipping to flush. The
// fill phase streams one pixel a cycle through an eight-stage exponent
// pipeline, the reciprocal of the patch sum comes from a 33-step serial
// divider, and the emit phase reads the buffer one pixel a cycle. Reset
// clears control state and restores the registers to radius 3 and a 4096 by
// 4096 image. The result side cannot stall: each result stands for exactly
// one cycle. cfg_ready is always high.
`default_nettype none
module elliptical_gaussian_patch
    import elg_pkg::*;
#(
    parameter int MAX_RADIUS      = 4,
    parameter int FRAC_BITS       = 8,
    parameter int EXP_TABLE_DEPTH = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire elg_req_t             request,
    output logic                      result_valid,
    output elg_res_t                  result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int SIDE = 2 * MAX_RADIUS;
    localparam int PW   = (SIDE > 2) ? $clog2(SIDE) : 1;

    elg_cmd_t      cmd;
    elg_sts_t      sts;
    logic [PW-1:0] col, row, wm1, hm1;

    // registers take every write at once
    assign cfg_ready = 1'b1;

    elg_ctrl #(.PW(PW)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .wm1   (wm1),
        .hm1   (hm1),
        .cmd   (cmd),
        .col   (col),
        .row   (row),
        .busy  (busy)
    );

    elg_datapath #(
        .MAX_RADIUS      (MAX_RADIUS),
        .FRAC_BITS       (FRAC_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .request      (request),
        .cmd          (cmd),
        .col          (col),
        .row          (row),
        .sts          (sts),
        .wm1          (wm1),
        .hm1          (hm1),
        .result       (result),
        .result_valid (result_valid)
    );

    // no pixel work is issued while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !cmd.fill_vld && !cmd.rd_vld && !cmd.div_go)
        else $error("pixel work issued while idle");

    // the divider starts only after the fill pipeline has drained
    a_div_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_go |-> !sts.fill_busy)
        else $error("divider started with fill in flight");

    // an empty box gives a single, final result
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.empty_patch |-> result.last)
        else $error("empty result not marked last");

    // an accepted request holds the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

endmodule
`default_nettype wire

[sim/elliptical_gaussian_patch_test.sv]
// Self-checking testbench of the elliptical Gaussian patch block.
`default_nettype none
import elg_pkg::*;

class patch_scoreboard;
    int unsigned radius_q = 3;
    int unsigned cols_q   = 4096;
    int unsigned rows_q   = 4096;
    int          failures = 0;
    elg_res_t    pixels_due[$];
    int unsigned exp_table[64];

    function new();
        longint unsigned a, term, pos, neg;
        for (int k = 0; k < 64; k++)
        begin
            a = (longint'(k) * LN2_Q32) / 64;
            term = 64'd1 << 32;
            pos = term;
            neg = 0;
            for (int n = 1; n <= 16; n++)
            begin
                term = ((term * a) >> 32) / n;
                if (n % 2 == 1) neg += term; else pos += term;
            end
            exp_table[k] = int'(((pos - neg) + (64'd1 << 16)) >> 17);
        end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        if (idx == CFG_RADIUS) radius_q = val[2:0];
        else if (idx == CFG_COLS) cols_q = val;
        else if (idx == CFG_ROWS) rows_q = val;
    endfunction

    // divide by 2^s, ties away from zero
    function longint round_shift(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function int unsigned spot_level(longint dx, longint dy, elg_req_t rq);
        longint cs, sn, xt, yt, u, v;
        longint unsigned w, ip, k;
        cs = longint'(rq.cos_angle);
        sn = longint'(rq.sin_angle);
        xt = round_shift(dx * cs + dy * sn, 14);
        yt = round_shift(dy * cs - dx * sn, 14);
        u = round_shift(xt * longint'(rq.inv_major), 12);
        v = round_shift(yt * longint'(rq.inv_minor), 12);
        w = longint'(u * u + v * v) * HALF_LOG2E_Q16;
        w = (w + (64'd1 << 15)) >> 16;
        ip = w >> 16;
        k = ((w & 64'hFFFF) * 64 + 32768) >> 16;
        if (k >= 64)
        begin
            k -= 64;
            ip++;
        end
        if (ip >= 16) return 0;
        return exp_table[k] >> ip;
    endfunction

    // clip one axis, return size and origin
    function longint clip_span(longint ctr, longint r, int unsigned dim, output longint org);
        longint lo, hi, lim;
        lo = ctr - r * 256;
        hi = ctr + r * 256;
        lim = longint'(dim) - 1;
        org = (lo < 0) ? 0 : lo / 256;
        if (hi > lim * 256) return lim - org;
        return hi / 256 - org;
    endfunction

    // Work out every pixel that one accepted request must produce.
    function void note_request(elg_req_t rq);
        longint r, ox, oy, w, h;
        longint unsigned total, rcp, p;
        int unsigned level[8][8];
        elg_res_t e;
        r = (radius_q > 4) ? 4 : radius_q;
        w = clip_span(longint'(rq.center_x), r, cols_q, ox);
        h = clip_span(longint'(rq.center_y), r, rows_q, oy);
        e = '0;
        e.offset_x = ox[11:0];
        e.offset_y = oy[11:0];
        if (w <= 0 || h <= 0)
        begin
            e.empty_patch = 1'b1;
            e.last = 1'b1;
            pixels_due.push_back(e);
            return;
        end
        if (w > 8) w = 8;
        if (h > 8) h = 8;
        total = 0;
        for (int c = 0; c < w; c++)
            for (int rw = 0; rw < h; rw++)
            begin
                level[c][rw] = spot_level((ox + c) * 256 - longint'(rq.center_x),
                                          (oy + rw) * 256 - longint'(rq.center_y), rq);
                total = (total + level[c][rw]) & 64'hFFFFFF;
            end
        rcp = (total != 0) ? (64'd1 << 32) / total : 0;
        for (int c = 0; c < w; c++)
            for (int rw = 0; rw < h; rw++)
            begin
                p = (level[c][rw] * rcp + 32768) >> 16;
                e.pixel_value = (p > 65535) ? 16'hFFFF : p[15:0];
                e.tile_col = c[2:0];
                e.tile_row = rw[2:0];
                e.last = (c == w - 1 && rw == h - 1);
                pixels_due.push_back(e);
            end
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        failures++;
    endtask

    task check_pixel(elg_res_t got);
        elg_res_t want;
        if (pixels_due.size() == 0)
        begin
            report("unexpected result, pixel_value", got.pixel_value, -1);
            return;
        end
        want = pixels_due.pop_front();
        if (got.pixel_value != want.pixel_value)
            report("pixel_value", got.pixel_value, want.pixel_value);
        if (got.tile_col != want.tile_col) report("tile_col", got.tile_col, want.tile_col);
        if (got.tile_row != want.tile_row) report("tile_row", got.tile_row, want.tile_row);
        if (got.offset_x != want.offset_x) report("offset_x", got.offset_x, want.offset_x);
        if (got.offset_y != want.offset_y) report("offset_y", got.offset_y, want.offset_y);
        if (got.empty_patch != want.empty_patch)
            report("empty_patch", got.empty_patch, want.empty_patch);
        if (got.last != want.last) report("last", got.last, want.last);
    endtask
endclass

module elliptical_gaussian_patch_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    elg_req_t             request;
    logic                 result_valid;
    elg_res_t             result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    patch_scoreboard sb;

    elliptical_gaussian_patch u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every result strobe; the receiver never stalls.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_pixel(result);
    end

    // Hold a request until the transfer happens, after a random gap.
    task send_request(elg_req_t rq);
        int gap;
        gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy);
        sb.note_request(rq);
    endtask

    // Drop start and wait until every pixel has drained and the block is idle.
    task drain_block();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pixels_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task apply_setting(int r, int cols, int rows);
        drain_block();
        write_reg(CFG_RADIUS, CFG_DAT_W'(r));
        write_reg(CFG_COLS, CFG_DAT_W'(cols));
        write_reg(CFG_ROWS, CFG_DAT_W'(rows));
    endtask

    function elg_req_t make_req(int cx, int cy, int cs, int sn, int ia, int ib);
        elg_req_t rq;
        rq.center_x  = cx[19:0];
        rq.center_y  = cy[19:0];
        rq.cos_angle = cs[15:0];
        rq.sin_angle = sn[15:0];
        rq.inv_major = ia[15:0];
        rq.inv_minor = ib[15:0];
        return rq;
    endfunction

    // Mostly plausible spots inside the image; some pure noise.
    function elg_req_t random_req();
        elg_req_t rq;
        int span_x, span_y, cs, sn;
        if ($urandom_range(0, 4) == 0)
        begin
            rq = $bits(elg_req_t)'({$urandom, $urandom, $urandom, $urandom});
            return rq;
        end
        span_x = (sb.cols_q + 1) * 256;
        span_y = (sb.rows_q + 1) * 256;
        if (span_x > 1048575) span_x = 1048575;
        if (span_y > 1048575) span_y = 1048575;
        cs = $urandom_range(0, 16384);
        sn = $urandom_range(0, 16384);
        if ($urandom % 2) cs = -cs;
        if ($urandom % 2) sn = -sn;
        return make_req($urandom_range(0, span_x), $urandom_range(0, span_y), cs, sn,
                        $urandom_range(600, 16000), $urandom_range(600, 16000));
    endfunction

    int phase_r[9]    = '{3, 4, 1, 2, 7, 0, 4, 4, 1};
    int phase_cols[9] = '{4096, 4096, 2, 17, 30, 50, 2, 4096, 1};
    int phase_rows[9] = '{4096, 4096, 2, 9, 30, 50, 4096, 3, 0};
    int phase_n[9]    = '{90, 90, 40, 60, 60, 10, 50, 60, 10};

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset setting.
        send_request(make_req(0, 0, 16384, 0, 4096, 4096));
        send_request(make_req(1048575, 1048575, 16384, 0, 4096, 4096));
        send_request(make_req(1048575, 0, -16384, 16384, 2048, 8192));
        send_request(make_req(2048 + 128, 3000, -32768, 32767, 4096, 4096));
        send_request(make_req(5000, 5000, 32767, -32768, 4096, 4096));
        send_request(make_req(6000, 7000, 11585, 11585, 0, 3000));
        send_request(make_req(6000, 7000, 11585, -11585, 0, 0));
        send_request(make_req(9000, 9000, 16384, 0, 65535, 65535));
        send_request(make_req(9100, 9300, 0, 16384, 1, 65535));
        send_request(make_req(100, 100, 0, -16384, 1, 1));
        send_request(make_req(1048320, 1048575, 16384, 0, 3000, 3000));
        send_request(make_req(768, 1048575, 16384, 0, 3000, 3000));

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph > 0)
                apply_setting(phase_r[ph], phase_cols[ph], phase_rows[ph]);
            if (ph == 2)
            begin
                send_request(make_req(0, 0, 16384, 0, 4096, 4096));
                send_request(make_req(511, 511, 16384, 0, 4096, 4096));
            end
            for (int i = 0; i < phase_n[ph]; i++)
                send_request(random_req());
        end

        drain_block();
        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
